[hdl/signed_integer_to_decimal_ascii_unit_defines.svh]
// ----------------------------------------------------------------------------
// signed integer to decimal ascii unit: assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SITDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// widths, character codes and controller/datapath bundles of the converter
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

	localparam int VALUE_WIDTH = 64;

	// number of decimal digits of the largest magnitude, 2^(width-1)
	function automatic int digits_for(input int width);
		longint unsigned m;
		int n;
		m = 64'd1 << (width - 1);
		n = 0;
		while (m != 64'd0) begin
			n = n + 1;
			m = m / 10;
		end
		return n;
	endfunction

	localparam int DIGIT_COUNT = digits_for(VALUE_WIDTH);
	localparam int BCD_W       = 4 * DIGIT_COUNT;
	localparam int STEP_W      = $clog2(VALUE_WIDTH);
	localparam int LEN_W       = $clog2(DIGIT_COUNT + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic load;
		logic dabble;
		logic trim;
		logic put_sign;
		logic put_digit;
	} sitda_cmd_t;

	typedef struct packed {
		logic conv_done;
		logic trim_more;
		logic neg;
		logic out_free;
		logic last_digit;
	} sitda_status_t;

endpackage

`default_nettype wire

[hdl/sitda_if.sv]
// ----------------------------------------------------------------------------
// sitda channel interfaces
// valid/ready channels for the input number and the output characters
// ----------------------------------------------------------------------------
`default_nettype none

interface sitda_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

[hdl/signed_integer_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// signed_integer_to_decimal_ascii_unit
// signed binary number in, its decimal ascii text out, one character per beat
// ----------------------------------------------------------------------------
// Takes one signed 64-bit number per input beat and sends its decimal text,
// most significant character first, one ASCII character per output beat,
// with last set on the final character. Negative numbers start with '-',
// the most negative value converts exactly, zero gives a single '0' and
// there are no leading zeros; 1 to 20 characters per number. The number is
// converted by a 64-step shift-and-add-3 loop into a 19-digit BCD register,
// then leading zero digits are dropped one per cycle, then the characters
// leave through a single output register at one per cycle while the output
// is not stalled. The input is taken only between numbers; the last character
// of one number may still wait in the output register while the next
// number is accepted and converted. No state is kept between numbers and
// reset only clears the controller, the step and length counters and the
// output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_decimal_ascii_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sitda_in_if.sink    number,
	sitda_out_if.source text
);
	import sitda_pkg::*;

	// command and status between sequencer and datapath
	sitda_cmd_t    cmd;
	sitda_status_t status;

	// sequencer: owns the input handshake
	sitda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number.valid),
		.in_ready (number.ready),
		.cmd      (cmd),
		.status   (status)
	);

	// datapath: conversion registers and the output register
	sitda_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.value         (number.value),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (text.ready),
		.out_valid     (text.valid),
		.out_character (text.character),
		.out_last      (text.last)
	);

endmodule

`default_nettype wire

[hdl/sitda_ctrl.sv]
// ----------------------------------------------------------------------------
// sitda_ctrl
// sequencer: load, shift-and-add-3 steps, zero trim, sign and digit output
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	output sitda_pkg::sitda_cmd_t        cmd,
	input  wire sitda_pkg::sitda_status_t status
);
	import sitda_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_TRIM = 3'd2;
	localparam logic [2:0] S_SIGN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				cmd.dabble = 1'b1;
				if (status.conv_done) begin
					state_d = S_TRIM;
				end
			end
			S_TRIM: begin
				if (status.trim_more) begin
					cmd.trim = 1'b1;
				end else begin
					state_d = status.neg ? S_SIGN : S_EMIT;
				end
			end
			S_SIGN: begin
				if (status.out_free) begin
					cmd.put_sign = 1'b1;
					state_d      = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.put_digit = 1'b1;
					if (status.last_digit) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[hdl/sitda_dp.sv]
// ----------------------------------------------------------------------------
// sitda_dp
// magnitude shifter, bcd register, digit counter and output register
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [63:0]           value,
	input  wire sitda_pkg::sitda_cmd_t cmd,
	output sitda_pkg::sitda_status_t   status,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [7:0]                 out_character,
	output logic                       out_last
);
	import sitda_pkg::*;

	logic [VALUE_WIDTH-1:0] v_in;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic [3:0]             top_digit;
	logic [STEP_W-1:0]      step_q;
	logic [LEN_W-1:0]       len_q;
	logic                   neg_q;
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   out_last_q;

	assign v_in      = value[VALUE_WIDTH-1:0];
	assign mag_in    = v_in[VALUE_WIDTH-1] ? (~v_in + 1'b1) : v_in;
	assign top_digit = bcd_q[BCD_W-1 -: 4];

	// add 3 to every digit of five or more ahead of the shift
	always_comb begin
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
				: bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		status            = '0;
		status.conv_done  = (step_q == STEP_W'(VALUE_WIDTH - 1));
		status.trim_more  = (top_digit == 4'd0) && (len_q != LEN_W'(1));
		status.neg        = neg_q;
		status.out_free   = !out_valid_q || out_ready;
		status.last_digit = (len_q == LEN_W'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag_in;
			bcd_q <= '0;
			neg_q <= v_in[VALUE_WIDTH-1];
		end else if (cmd.dabble) begin
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
		end else if (cmd.trim || cmd.put_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
		if (cmd.put_sign) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (cmd.put_digit) begin
			out_char_q <= CHAR_ZERO + {4'd0, top_digit};
			out_last_q <= status.last_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				step_q <= '0;
				len_q  <= LEN_W'(DIGIT_COUNT);
			end else begin
				if (cmd.dabble) begin
					step_q <= step_q + 1'b1;
				end
				if (cmd.trim || cmd.put_digit) begin
					len_q <= len_q - 1'b1;
				end
			end
			if (cmd.put_sign || cmd.put_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_character = out_char_q;
	assign out_last      = out_last_q;

endmodule

`default_nettype wire

[hdl/sitda_checker.sv]
// ----------------------------------------------------------------------------
// sitda_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_integer_to_decimal_ascii_unit_defines.svh"

module sitda_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       number_valid,
	input wire logic       number_ready,
	input wire logic       text_valid,
	input wire logic       text_ready,
	input wire logic [7:0] text_character,
	input wire logic       text_last
);
	import sitda_pkg::*;

	// output beat holds until taken
	`SITDA_ASSERT_NEXT(a_text_hold, text_valid && !text_ready, text_valid, "text valid dropped")
	`SITDA_ASSERT_NEXT(a_text_stable, text_valid && !text_ready,
		$stable(text_character) && $stable(text_last), "text payload changed while stalled")

	// a number is being converted right after it is taken
	`SITDA_ASSERT_NEXT(a_busy_after_take, number_valid && number_ready, !number_ready,
		"input ready right after an accepted number")

	// only digits and the minus sign come out
	`SITDA_ASSERT_NOW(a_char_set, text_valid,
		((text_character >= CHAR_ZERO) && (text_character <= CHAR_NINE))
		|| (text_character == CHAR_MINUS), "character outside digits and minus")

	// a sign is always followed by digits
	`SITDA_ASSERT_NOW(a_sign_not_last, text_valid && (text_character == CHAR_MINUS), !text_last,
		"minus sign flagged as last")

endmodule

bind signed_integer_to_decimal_ascii_unit sitda_checker u_sitda_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.number_valid   (number.valid),
	.number_ready   (number.ready),
	.text_valid     (text.valid),
	.text_ready     (text.ready),
	.text_character (text.character),
	.text_last      (text.last)
);

`default_nettype wire
